[hdl/alsbp_pkg.sv]
// shared constants and types for the access log status and bytes parser
`default_nettype none

package alsbp_pkg;

  localparam int BYTE_W            = 8;
  localparam int STATUS_W          = 16;
  localparam int COUNT_WIDTH       = 40;
  localparam int BYTES_FIELD_WIDTH = 48;
  localparam int BYTES_MAG_W       = BYTES_FIELD_WIDTH - 1;
  localparam int SUM_W             = 64;

  localparam logic [STATUS_W-1:0] TARGET_RESET = STATUS_W'(404);

  // summary of one finished line, handed from the parser to the accumulator
  typedef struct packed {
    logic                   parsed;
    logic                   matched;
    logic                   negative;
    logic [BYTES_MAG_W-1:0] magnitude;
  } line_sum_t;

endpackage

`default_nettype wire

[hdl/alsbp_parse.sv]
// per-line scanner: quote-space search and status / bytes number parsing
`default_nettype none

module alsbp_parse (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             take,
  input  wire logic [alsbp_pkg::BYTE_W-1:0]     log_byte,
  input  wire logic                             last_of_line,
  input  wire logic [alsbp_pkg::STATUS_W-1:0]   target_status,
  output alsbp_pkg::line_sum_t                  line_sum
);
  import alsbp_pkg::*;

  localparam logic [2:0] PH_SEARCH        = 3'd0;
  localparam logic [2:0] PH_PRE_STATUS    = 3'd1;
  localparam logic [2:0] PH_STATUS_SIGN   = 3'd2;
  localparam logic [2:0] PH_STATUS_DIGITS = 3'd3;
  localparam logic [2:0] PH_PRE_BYTES     = 3'd4;
  localparam logic [2:0] PH_BYTES_SIGN    = 3'd5;
  localparam logic [2:0] PH_BYTES_DIGITS  = 3'd6;
  localparam logic [2:0] PH_DEAD          = 3'd7;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  localparam int STAT_EXT_W = STATUS_W + 4;
  localparam int BYT_EXT_W  = BYTES_MAG_W + 4;

  logic [2:0]             phase_r, phase_nxt;
  logic                   prev_q_r, prev_q_nxt;
  logic [STATUS_W-1:0]    stat_val_r, stat_val_nxt;
  logic                   stat_neg_r, stat_neg_nxt;
  logic [BYTES_MAG_W-1:0] byt_val_r, byt_val_nxt;
  logic                   byt_neg_r, byt_neg_nxt;

  logic                   is_space, is_digit, is_sign;
  logic [3:0]             digit;
  logic [STAT_EXT_W-1:0]  stat_ext, stat_mul;
  logic [STATUS_W-1:0]    stat_step;
  logic [BYT_EXT_W-1:0]   byt_ext, byt_mul;
  logic [BYTES_MAG_W-1:0] byt_step;

  assign is_space = (log_byte == CH_SPACE) || (log_byte >= CH_TAB && log_byte <= CH_CR);
  assign is_digit = (log_byte >= CH_ZERO) && (log_byte <= CH_NINE);
  assign is_sign  = (log_byte == CH_PLUS) || (log_byte == CH_MINUS);
  assign digit    = log_byte[3:0];

  // value*10 + digit as two shifts and two adds, saturating
  assign stat_ext  = {4'b0, stat_val_r};
  assign stat_mul  = (stat_ext << 3) + (stat_ext << 1) + {{(STAT_EXT_W-4){1'b0}}, digit};
  assign stat_step = (|stat_mul[STAT_EXT_W-1:STATUS_W]) ? {STATUS_W{1'b1}}
                                                        : stat_mul[STATUS_W-1:0];

  assign byt_ext  = {4'b0, byt_val_r};
  assign byt_mul  = (byt_ext << 3) + (byt_ext << 1) + {{(BYT_EXT_W-4){1'b0}}, digit};
  assign byt_step = (|byt_mul[BYT_EXT_W-1:BYTES_MAG_W]) ? {BYTES_MAG_W{1'b1}}
                                                        : byt_mul[BYTES_MAG_W-1:0];

  always_comb begin
    phase_nxt    = phase_r;
    prev_q_nxt   = prev_q_r;
    stat_val_nxt = stat_val_r;
    stat_neg_nxt = stat_neg_r;
    byt_val_nxt  = byt_val_r;
    byt_neg_nxt  = byt_neg_r;
    unique case (phase_r)
      PH_SEARCH: begin
        if (log_byte == CH_NUL) begin
          phase_nxt = PH_DEAD;
        end else if (prev_q_r && log_byte == CH_SPACE) begin
          phase_nxt  = PH_PRE_STATUS;
          prev_q_nxt = 1'b0;
        end else begin
          prev_q_nxt = (log_byte == CH_QUOTE);
        end
      end
      PH_PRE_STATUS: begin
        if (is_space) begin
          phase_nxt = PH_PRE_STATUS;
        end else if (is_sign) begin
          stat_neg_nxt = (log_byte == CH_MINUS);
          phase_nxt    = PH_STATUS_SIGN;
        end else if (is_digit) begin
          stat_val_nxt = stat_step;
          phase_nxt    = PH_STATUS_DIGITS;
        end else begin
          phase_nxt = PH_DEAD;
        end
      end
      PH_STATUS_SIGN: begin
        if (is_digit) begin
          stat_val_nxt = stat_step;
          phase_nxt    = PH_STATUS_DIGITS;
        end else begin
          phase_nxt = PH_DEAD;
        end
      end
      PH_STATUS_DIGITS: begin
        if (is_digit) begin
          stat_val_nxt = stat_step;
        end else if (is_space) begin
          phase_nxt = PH_PRE_BYTES;
        end else if (is_sign) begin
          byt_neg_nxt = (log_byte == CH_MINUS);
          phase_nxt   = PH_BYTES_SIGN;
        end else begin
          phase_nxt = PH_DEAD;
        end
      end
      PH_PRE_BYTES: begin
        if (is_space) begin
          phase_nxt = PH_PRE_BYTES;
        end else if (is_sign) begin
          byt_neg_nxt = (log_byte == CH_MINUS);
          phase_nxt   = PH_BYTES_SIGN;
        end else if (is_digit) begin
          byt_val_nxt = byt_step;
          phase_nxt   = PH_BYTES_DIGITS;
        end else begin
          phase_nxt = PH_DEAD;
        end
      end
      PH_BYTES_SIGN: begin
        if (is_digit) begin
          byt_val_nxt = byt_step;
          phase_nxt   = PH_BYTES_DIGITS;
        end else begin
          phase_nxt = PH_DEAD;
        end
      end
      PH_BYTES_DIGITS: begin
        // prev_q doubles as "bytes number closed" here
        if (!prev_q_r) begin
          if (is_digit) begin
            byt_val_nxt = byt_step;
          end else begin
            prev_q_nxt = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_DEAD;
      end
    endcase
  end

  always_comb begin
    line_sum.parsed    = (phase_nxt == PH_BYTES_DIGITS);
    line_sum.matched   = (phase_nxt == PH_BYTES_DIGITS) && (stat_val_nxt == target_status) &&
                         (!stat_neg_nxt || stat_val_nxt == '0);
    line_sum.negative  = byt_neg_nxt;
    line_sum.magnitude = byt_val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && last_of_line)) begin
      phase_r    <= PH_SEARCH;
      prev_q_r   <= 1'b0;
      stat_val_r <= '0;
      stat_neg_r <= 1'b0;
      byt_val_r  <= '0;
      byt_neg_r  <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      prev_q_r   <= prev_q_nxt;
      stat_val_r <= stat_val_nxt;
      stat_neg_r <= stat_neg_nxt;
      byt_val_r  <= byt_val_nxt;
      byt_neg_r  <= byt_neg_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/access_log_status_bytes_parser_unit.sv]
// top level: access log status / bytes parser with running totals
// a line's last word moves from the input register to the line summary register, then to the output register
// throughput: one word per cycle unless out_stall backs up the pipe; the scanner state advances once per byte
// three stages (input register, scanner, accumulator) each stall only when full
// reset: synchronous active-low rst_n clears line state, totals, valids;
// target status returns to 404, no clearing pass
`default_nettype none

module access_log_status_bytes_parser_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // input channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [alsbp_pkg::BYTE_W-1:0]           in_log_byte,
  input  wire logic                                   in_last_of_line,
  // result channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [alsbp_pkg::SUM_W-1:0]          out_byte_total,
  output logic [alsbp_pkg::COUNT_WIDTH-1:0]           out_match_count,
  output logic                                        out_line_parsed,
  output logic                                        out_line_matched,
  // configuration
  input  wire logic                                   cfg_we,
  input  wire logic [alsbp_pkg::STATUS_W-1:0]         cfg_wdata
);
  import alsbp_pkg::*;

  // target status register
  logic [STATUS_W-1:0] target_r;

  // stage 1: input word register
  logic                s1_v_r;
  logic [BYTE_W-1:0]   s1_byte_r;
  logic                s1_last_r;

  // stage 2: finished line summary
  logic                s2_v_r;
  line_sum_t           s2_sum_r;

  // stage 3: running totals and output register
  logic                out_v_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                parsed_r, matched_r;

  logic                s3_free, s2_ready, s1_take;
  line_sum_t           line_sum;
  logic [SUM_W-1:0]    mag_ext;

  // each stage moves when the one after it has room
  assign s3_free  = !out_v_r || !out_stall;
  assign s2_ready = !s2_v_r || s3_free;
  assign s1_take  = s1_v_r && s2_ready;
  assign in_stall = s1_v_r && !s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
    end else if (cfg_we) begin
      target_r <= cfg_wdata;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_log_byte;
      s1_last_r <= in_last_of_line;
    end
  end

  // stage 2: scanner updates its line state on every word taken
  alsbp_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (s1_take),
    .log_byte      (s1_byte_r),
    .last_of_line  (s1_last_r),
    .target_status (target_r),
    .line_sum      (line_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_take && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_last_r) begin
      s2_sum_r <= line_sum;
    end
  end

  // stage 3: signed add of the bytes count, saturating match counter
  assign mag_ext = {{(SUM_W-BYTES_MAG_W){1'b0}}, s2_sum_r.magnitude};

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (s2_sum_r.parsed) begin
      sum_nxt = s2_sum_r.negative ? (sum_r - mag_ext) : (sum_r + mag_ext);
    end
    if (s2_sum_r.matched && !(&cnt_r)) begin
      cnt_nxt = cnt_r + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sum_r   <= '0;
      cnt_r   <= '0;
    end else if (s3_free) begin
      out_v_r <= s2_v_r;
      if (s2_v_r) begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && s2_v_r) begin
      parsed_r  <= s2_sum_r.parsed;
      matched_r <= s2_sum_r.matched;
    end
  end

  assign out_valid        = out_v_r;
  assign out_byte_total   = sum_r;
  assign out_match_count  = cnt_r;
  assign out_line_parsed  = parsed_r;
  assign out_line_matched = matched_r;

endmodule

`default_nettype wire

[test/access_log_status_bytes_parser_unit_tb.sv]
// testbench for the access log status / bytes parser: directed lines, random log traffic, scoreboard
module access_log_status_bytes_parser_unit_tb;
  import alsbp_pkg::*;

  localparam int SETTLE_CYCLES = 8;     // a little over the three-stage latency
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, enough to back up the pipe
  localparam int PHASE_WORDS   = 350;   // words per random phase, four phases
  localparam int KEEP_TARGET   = -1;    // directed row leaves the target register alone
  localparam int N_DIRECTED    = 28;
  localparam longint unsigned BYTES_CAP = (64'd1 << BYTES_MAG_W) - 64'd1;
  localparam logic [COUNT_WIDTH-1:0] HITS_CAP = '1;

  // parser phases, one per position in the "<quote><space> status bytes" grammar
  typedef enum logic [2:0] {
    SCAN_QUOTE,
    SCAN_PRE_STATUS,
    SCAN_STATUS_SIGN,
    SCAN_STATUS_DIGITS,
    SCAN_PRE_BYTES,
    SCAN_BYTES_SIGN,
    SCAN_BYTES_DIGITS,
    SCAN_DEAD
  } scan_phase_t;

  typedef struct {
    logic [SUM_W-1:0]       total;
    logic [COUNT_WIDTH-1:0] hits;
    logic                   parsed;
    logic                   matched;
  } line_result_t;

  // one directed log line; '@' in the text stands for a zero byte
  typedef struct {
    int           new_tgt;
    string        text;
    bit           typed;
    line_result_t want;
  } directed_line_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [BYTE_W-1:0]             in_log_byte = '0;
  logic                          in_last_of_line = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SUM_W-1:0]       out_byte_total;
  logic [COUNT_WIDTH-1:0]        out_match_count;
  logic                          out_line_parsed;
  logic                          out_line_matched;
  logic                          cfg_we = 1'b0;
  logic [STATUS_W-1:0]           cfg_wdata = '0;

  // mirror of the block: per-line scan state plus the running totals
  scan_phase_t            scan_ph = SCAN_QUOTE;
  logic                   prev_quote = 1'b0;  // quote seen while searching, or bytes closed
  int unsigned            stat_mag = 0;
  logic                   stat_neg = 1'b0;
  longint unsigned        byte_mag = 0;
  logic                   byte_neg = 1'b0;
  logic [SUM_W-1:0]       run_total = '0;
  logic [COUNT_WIDTH-1:0] run_hits = '0;
  logic [STATUS_W-1:0]    tgt = TARGET_RESET;

  line_result_t pending_lines[$];   // expected line results, oldest first
  line_result_t pinned;             // hand-typed result for the current directed line
  bit           pin_armed = 1'b0;
  logic [7:0]   line_buf[$];        // bytes of the line about to be sent
  int           mismatches = 0;
  int           send_pct = 0;       // chance per cycle that the sender sits idle
  int           recv_pct = 0;       // chance per cycle that the receiver stalls
  bit           hold_arm = 1'b0;    // toggled to request one long hold-off
  bit           hold_ack = 1'b0;
  int           hold_left = 0;

  directed_line_t directed_lines [N_DIRECTED] = '{
    // plain hit right after reset
    '{KEEP_TARGET, "\" 404 100",    1'b1, '{64'd100, 40'd1, 1'b1, 1'b1}},
    // no quote-space pair anywhere
    '{KEEP_TARGET, "GET / 404 5",   1'b1, '{64'd100, 40'd1, 1'b0, 1'b0}},
    // sign glued to the status starts the bytes count
    '{KEEP_TARGET, "\" 404-5",      1'b1, '{64'd95, 40'd2, 1'b1, 1'b1}},
    // zero byte closes a bytes count that is already in its digits
    '{KEEP_TARGET, "\" 200 12@junk", 1'b1, '{64'd107, 40'd2, 1'b1, 1'b0}},
    // zero byte inside the status kills the line
    '{KEEP_TARGET, "\" 200@ 5",     1'b1, '{64'd107, 40'd2, 1'b0, 1'b0}},
    // status and bytes both saturate
    '{KEEP_TARGET, "\" 99999 999999999999999999", 1'b1,
      '{64'd140737488355434, 40'd2, 1'b1, 1'b0}},
    // a line that is nothing but a zero byte
    '{KEEP_TARGET, "@",             1'b1, '{64'd140737488355434, 40'd2, 1'b0, 1'b0}},
    '{KEEP_TARGET, "x\"\" \t+404\v\f+3", 1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\" 2x0 5",      1'b0, '{0, 0, 0, 0}},
    // a later quote-space pair does not restart a dead line
    '{KEEP_TARGET, "\" x\" 404 5",  1'b0, '{0, 0, 0, 0}},
    // line ends before any bytes digit
    '{KEEP_TARGET, "\" 404",        1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\" 404 ",       1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\" 404 -",      1'b0, '{0, 0, 0, 0}},
    // junk after the bytes digits is ignored
    '{KEEP_TARGET, "\" 200 12a34 99", 1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\377\" 404\r\n-2", 1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\" -404 1",     1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\" -0 7",       1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\"  +",         1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\"\"\" 404 3\"", 1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\" 0404 8",     1'b0, '{0, 0, 0, 0}},
    // target zero: negative zero matches, other negatives do not
    '{0,           "\" -0 7",       1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\" 0 1",        1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\" -5 1",       1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\" 00 -00",     1'b0, '{0, 0, 0, 0}},
    // top target: a saturated status counts as a hit
    '{65535,       "\" 99999 1",    1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\" 65535 2",    1'b0, '{0, 0, 0, 0}},
    '{KEEP_TARGET, "\" -65535 3",   1'b0, '{0, 0, 0, 0}},
    // tab after the quote is not a quote-space pair
    '{KEEP_TARGET, "\"\t404 1",     1'b0, '{0, 0, 0, 0}}
  };

  access_log_status_bytes_parser_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_log_byte      (in_log_byte),
    .in_last_of_line  (in_last_of_line),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_total   (out_byte_total),
    .out_match_count  (out_match_count),
    .out_line_parsed  (out_line_parsed),
    .out_line_matched (out_line_matched),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void add_status_digit(logic [7:0] c);
    int unsigned v;
    v = stat_mag * 10 + (c - "0");
    stat_mag = (v > 65535) ? 65535 : v;
  endfunction

  function automatic void add_bytes_digit(logic [7:0] c);
    longint unsigned d;
    d = c - "0";
    if (byte_mag > (BYTES_CAP - d) / 10) byte_mag = BYTES_CAP;
    else byte_mag = byte_mag * 10 + d;
  endfunction

  // advance the line scanner by one character
  function automatic void scan_byte(logic [7:0] c);
    case (scan_ph)
      SCAN_QUOTE: begin
        if (c == 8'h00) begin
          scan_ph = SCAN_DEAD;
        end else if (prev_quote && c == 8'h20) begin
          scan_ph = SCAN_PRE_STATUS;
          prev_quote = 1'b0;
        end else begin
          prev_quote = (c == "\"");
        end
      end
      SCAN_PRE_STATUS: begin
        if (is_blank(c)) begin
          // keep skipping
        end else if (c == "+" || c == "-") begin
          stat_neg = (c == "-");
          scan_ph = SCAN_STATUS_SIGN;
        end else if (is_digit(c)) begin
          add_status_digit(c);
          scan_ph = SCAN_STATUS_DIGITS;
        end else begin
          scan_ph = SCAN_DEAD;
        end
      end
      SCAN_STATUS_SIGN: begin
        if (is_digit(c)) begin
          add_status_digit(c);
          scan_ph = SCAN_STATUS_DIGITS;
        end else begin
          scan_ph = SCAN_DEAD;
        end
      end
      SCAN_STATUS_DIGITS: begin
        if (is_digit(c)) begin
          add_status_digit(c);
        end else if (is_blank(c)) begin
          scan_ph = SCAN_PRE_BYTES;
        end else if (c == "+" || c == "-") begin
          byte_neg = (c == "-");
          scan_ph = SCAN_BYTES_SIGN;
        end else begin
          scan_ph = SCAN_DEAD;
        end
      end
      SCAN_PRE_BYTES: begin
        if (is_blank(c)) begin
          // keep skipping
        end else if (c == "+" || c == "-") begin
          byte_neg = (c == "-");
          scan_ph = SCAN_BYTES_SIGN;
        end else if (is_digit(c)) begin
          add_bytes_digit(c);
          scan_ph = SCAN_BYTES_DIGITS;
        end else begin
          scan_ph = SCAN_DEAD;
        end
      end
      SCAN_BYTES_SIGN: begin
        if (is_digit(c)) begin
          add_bytes_digit(c);
          scan_ph = SCAN_BYTES_DIGITS;
        end else begin
          scan_ph = SCAN_DEAD;
        end
      end
      SCAN_BYTES_DIGITS: begin
        // first non-digit closes the count, everything after it is ignored
        if (!prev_quote) begin
          if (is_digit(c)) add_bytes_digit(c);
          else prev_quote = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // line end: fold the line into the totals and queue the expected result
  function automatic void close_line();
    line_result_t r;
    r.parsed  = (scan_ph == SCAN_BYTES_DIGITS);
    r.matched = 1'b0;
    if (r.parsed) begin
      run_total += byte_neg ? (64'd0 - byte_mag) : byte_mag;
      r.matched = (stat_mag == tgt) && (!stat_neg || stat_mag == 0);
      if (r.matched && run_hits != HITS_CAP) run_hits++;
    end
    r.total = run_total;
    r.hits  = run_hits;
    pending_lines.push_back(pin_armed ? pinned : r);
    pin_armed  = 1'b0;
    scan_ph    = SCAN_QUOTE;
    prev_quote = 1'b0;
    stat_mag   = 0;
    stat_neg   = 1'b0;
    byte_mag   = 0;
    byte_neg   = 1'b0;
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    line_result_t w;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_lines.size() == 0) begin
        $error("result word with no line pending");
        mismatches++;
      end else begin
        w = pending_lines.pop_front();
        if (out_byte_total !== w.total) begin
          $error("byte_total: expected %0d, got %0d", $signed(w.total), out_byte_total);
          mismatches++;
        end
        if (out_match_count !== w.hits) begin
          $error("match_count: expected %0d, got %0d", w.hits, out_match_count);
          mismatches++;
        end
        if (out_line_parsed !== w.parsed) begin
          $error("line_parsed: expected %0d, got %0d", w.parsed, out_line_parsed);
          mismatches++;
        end
        if (out_line_matched !== w.matched) begin
          $error("line_matched: expected %0d, got %0d", w.matched, out_line_matched);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off counted here on request
  always @(negedge clk) begin
    if (hold_arm != hold_ack) begin
      hold_ack  = hold_arm;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  // offer one word; the scanner mirror advances when the word is taken
  task automatic send_word(input logic [7:0] b, input logic l);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_log_byte     <= b;
    in_last_of_line <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_byte(b);
    if (l) close_line();
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_word(line_buf[i], i == line_buf.size() - 1);
  endtask

  // stop offering and wait until every queued line result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(input logic [STATUS_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tgt = v;
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void put_digits(int n);
    repeat (n) line_buf.push_back(8'("0" + $urandom_range(0, 9)));
  endfunction

  function automatic void put_blank();
    case ($urandom_range(0, 9))
      0: line_buf.push_back(8'h09);
      1: line_buf.push_back(8'h0A);
      2: line_buf.push_back(8'h0B);
      3: line_buf.push_back(8'h0C);
      4: line_buf.push_back(8'h0D);
      default: line_buf.push_back(8'h20);
    endcase
  endfunction

  // random log line: mostly well formed, some damaged, some pure noise
  function automatic void build_line();
    int kind;
    int sv;
    int bsign;
    int n;
    int idx;
    line_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = $urandom_range(1, 24);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) line_buf.push_back($urandom_range(0, 1) ? 8'h22 : 8'h20);
        else line_buf.push_back(8'($urandom_range(0, 255)));
      end
      return;
    end
    // prefix up to and including the quote-space pair
    case ($urandom_range(0, 2))
      0: put_text("h - - [t] \"GET / H1\" ");
      1: begin
        repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
        put_text("\" ");
      end
      default: put_text("\" ");
    endcase
    if ($urandom_range(0, 3) == 0) put_blank();
    // status
    case ($urandom_range(0, 9))
      0, 1, 2, 3: sv = tgt;
      4: sv = 200;
      5: sv = 404;
      6: sv = $urandom_range(0, 1) ? 0 : 65535;
      7: sv = $urandom_range(65536, 999999);
      default: sv = $urandom_range(0, 99999);
    endcase
    n = $urandom_range(0, 99);
    if (n < 10) put_text("-");
    else if (n < 20) put_text("+");
    if ($urandom_range(0, 9) == 0) put_text("0");
    put_text($sformatf("%0d", sv));
    // separator and bytes count
    bsign = $urandom_range(0, 99);
    if (bsign < 15 && $urandom_range(0, 99) < 30) begin
      // sign directly after the status digits
    end else begin
      repeat ($urandom_range(1, 3)) put_blank();
    end
    if (bsign < 10) put_text("-");
    else if (bsign < 15) put_text("+");
    put_digits($urandom_range(0, 19) == 0 ? $urandom_range(15, 20) : $urandom_range(1, 5));
    // trailer
    case ($urandom_range(0, 9))
      6, 7: put_text(" \"-\" \"ua\"");
      8: begin
        line_buf.push_back(8'h00);
        repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
      end
      9: repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
      default: begin
      end
    endcase
    // damaged lines: one byte overwritten or the tail cut off
    if (kind < 30) begin
      if ($urandom_range(0, 1)) begin
        idx = $urandom_range(0, line_buf.size() - 1);
        line_buf[idx] = 8'($urandom_range(0, 255));
      end else begin
        repeat ($urandom_range(1, line_buf.size() - 1)) void'(line_buf.pop_back());
      end
    end
  endfunction

  // ---------------------------------------------------------------- main sequence

  initial begin
    logic [7:0] ch;
    int         phase_words;
    bit         paused;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed lines, moderate idling on both sides
    send_pct = 30;
    recv_pct = 30;
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_lines[r].new_tgt != KEEP_TARGET)
        write_target(STATUS_W'(directed_lines[r].new_tgt));
      line_buf.delete();
      for (int i = 0; i < directed_lines[r].text.len(); i++) begin
        ch = directed_lines[r].text[i];
        line_buf.push_back(ch == "@" ? 8'h00 : ch);
      end
      pinned    = directed_lines[r].want;
      pin_armed = directed_lines[r].typed;
      send_line();
    end

    // random traffic in four idling phases, each under its own target
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_pct = 0;
          recv_pct = 0;
          write_target(TARGET_RESET);
        end
        1: begin
          send_pct = 72;
          recv_pct = 0;
          write_target(STATUS_W'($urandom_range(0, 65535)));
        end
        2: begin
          send_pct = 0;
          recv_pct = 72;
          write_target(STATUS_W'(200));
        end
        default: begin
          send_pct = 22;
          recv_pct = 22;
          write_target(STATUS_W'($urandom_range(0, 999)));
        end
      endcase
      // back-pressure: receiver goes quiet while the sender keeps pushing
      if (p == 0) hold_arm = ~hold_arm;
      phase_words = 0;
      paused      = 1'b0;
      while (phase_words < PHASE_WORDS) begin
        build_line();
        send_line();
        phase_words += line_buf.size();
        // sender pause: let the pipe empty out completely mid-phase
        if (p == 1 && !paused && phase_words >= PHASE_WORDS / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule
